// ===== design/ial_pkg.sv =====
// shared types and constants for the indexed array list
// operation and status codes, cell control and the probe token
// no dependencies
package ial_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 7;

	localparam logic [POS_W-1:0] FOUND_NONE = '1;

	typedef enum logic [2:0] {
		MODE_PUSH_BACK  = 3'd0,
		MODE_PUSH_FRONT = 3'd1,
		MODE_INSERT     = 3'd2,
		MODE_POP_BACK   = 3'd3,
		MODE_POP_FRONT  = 3'd4,
		MODE_REMOVE     = 3'd5,
		MODE_FIND       = 3'd6,
		MODE_GET        = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_SCAN = 1'b1
	} fsm_t;

	// per-cell update: load a new value or take the lower or upper neighbour
	typedef struct packed {
		logic load_new;
		logic take_lower;
		logic take_upper;
	} cell_ctl_t;

	// probe token walking the chain
	typedef struct packed {
		logic              live;
		logic              hit;
		logic [POS_W-1:0]  where;
		logic [DATA_W-1:0] value;
	} tok_t;

endpackage

// ===== design/ial_cell.sv =====
// one list cell: holds a single element and one stage of the probe chain
// depends on ial_pkg
module ial_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ial_pkg::cell_ctl_t            ctl,
	input  logic [ial_pkg::DATA_W-1:0]    new_value,
	input  logic [ial_pkg::DATA_W-1:0]    lower_value,
	input  logic [ial_pkg::DATA_W-1:0]    upper_value,
	input  logic [ial_pkg::DATA_W-1:0]    key,
	input  logic                          find_en,
	input  logic                          sel_pos,
	input  logic [ial_pkg::POS_W-1:0]     where,
	input  ial_pkg::tok_t                 tok_in,
	output ial_pkg::tok_t                 tok_out,
	output logic [ial_pkg::DATA_W-1:0]    value
);
	import ial_pkg::*;

	logic [DATA_W-1:0] elem_q;
	logic              live_q;
	logic              hit_q;
	logic [POS_W-1:0]  where_q;
	logic [DATA_W-1:0] value_q;
	logic              hit_here;

	always_ff @(posedge clk) begin
		if (ctl.load_new) begin
			elem_q <= new_value;
		end else if (ctl.take_lower) begin
			elem_q <= lower_value;
		end else if (ctl.take_upper) begin
			elem_q <= upper_value;
		end
	end

	// first cell to claim the token stamps its value and index
	assign hit_here = tok_in.live && !tok_in.hit && (sel_pos || (find_en && elem_q == key));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else begin
			live_q <= tok_in.live;
		end
	end

	always_ff @(posedge clk) begin
		hit_q <= tok_in.hit || hit_here;
		if (hit_here) begin
			where_q <= where;
			value_q <= elem_q;
		end else begin
			where_q <= tok_in.where;
			value_q <= tok_in.value;
		end
	end

	always_comb begin
		tok_out.live  = live_q;
		tok_out.hit   = hit_q;
		tok_out.where = where_q;
		tok_out.value = value_q;
	end

	assign value = elem_q;

endmodule

// ===== design/indexed_array_list.sv =====
// top level of the indexed array list: control, length and the cell chain
// depends on ial_pkg and ial_cell
//
// An ordered list of up to CAPACITY signed 32-bit values, one per cell.
// A command transfer happens on a clock edge with start high and busy low.
// Push back, push front, insert, pop front and every command that fails its
// index, empty or full check complete at once: the result strobe is high in
// the cycle after the transfer and busy never rises, so a new command can be
// taken on the very next edge. Pop back, remove, get and find need a value
// from a cell chosen at run time, so a probe token walks the cell chain one
// cell per cycle: the token is launched from a register after the transfer,
// the result strobe is registered as it leaves the last cell, and busy is
// high for the whole scan. Inserts and removals shift every cell at or above
// the affected index at once. Results are shown for exactly one cycle and
// cannot be held off; the receiver must take each strobe as it comes.
module indexed_array_list #(
	parameter int CAPACITY = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  ial_pkg::mode_t                    mode,
	input  logic [ial_pkg::POS_W-1:0]         position,
	input  logic signed [ial_pkg::DATA_W-1:0] item_value,
	output logic                              strobe,
	output ial_pkg::status_t                  status,
	output logic signed [ial_pkg::DATA_W-1:0] read_value,
	output logic signed [ial_pkg::POS_W-1:0]  found_at,
	output logic [ial_pkg::POS_W-1:0]         count
);
	import ial_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	// control state
	fsm_t              state_q, state_d;
	logic              launch_q;
	logic [CW-1:0]     used_q, used_next;

	// command held during a scan
	mode_t             mode_q;
	logic [IW-1:0]     tgt_q;
	logic [DATA_W-1:0] key_q;

	// result registers
	logic              strobe_q;
	status_t           status_q;
	logic [DATA_W-1:0] rd_q;
	logic [POS_W-1:0]  found_q;
	logic [POS_W-1:0]  count_q;

	// decode of the incoming command
	logic              acc;
	status_t           imm_status;
	logic              go_scan, ins_ok, popf_ok;
	logic [IW-1:0]     tgt_next;
	logic [XW-1:0]     pos_x, used_x, ins_at_x;

	// cell updates
	logic              do_ins, do_rem, fin_rem, done;
	logic [CW-1:0]     ins_at, rem_at;

	logic [DATA_W-1:0] elem [CAPACITY];
	tok_t              tok  [CAPACITY+1];
	logic [CAPACITY-1:0] live_vec;
	tok_t              tok_exit;

	assign acc    = start && !busy;
	assign pos_x  = XW'(position);
	assign used_x = XW'(used_q);

	// index, empty and full checks; decide between an immediate result and a scan
	always_comb begin
		imm_status = ST_OK;
		go_scan    = 1'b0;
		ins_ok     = 1'b0;
		popf_ok    = 1'b0;
		tgt_next   = '0;
		ins_at_x   = used_x;
		case (mode)
			MODE_PUSH_BACK, MODE_PUSH_FRONT, MODE_INSERT: begin
				if (mode == MODE_PUSH_FRONT) begin
					ins_at_x = '0;
				end else if (mode == MODE_INSERT) begin
					ins_at_x = pos_x;
				end
				if (ins_at_x > used_x) begin
					imm_status = ST_BAD_INDEX;
				end else if (used_q == CW'(CAPACITY)) begin
					imm_status = ST_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			MODE_POP_BACK: begin
				if (used_q == '0) begin
					imm_status = ST_EMPTY;
				end else begin
					go_scan  = 1'b1;
					tgt_next = IW'(used_q - 1'b1);
				end
			end
			MODE_POP_FRONT: begin
				if (used_q == '0) begin
					imm_status = ST_EMPTY;
				end else begin
					popf_ok = 1'b1;
				end
			end
			MODE_REMOVE, MODE_GET: begin
				if (pos_x >= used_x) begin
					imm_status = ST_BAD_INDEX;
				end else begin
					go_scan  = 1'b1;
					tgt_next = IW'(pos_x);
				end
			end
			MODE_FIND: begin
				go_scan = 1'b1;
			end
			default: begin
				imm_status = ST_OK;
			end
		endcase
	end

	// token leaving the last cell ends a scan
	assign tok_exit = tok[CAPACITY];
	assign done     = (state_q == FSM_SCAN) && tok_exit.live;
	assign fin_rem  = done && (mode_q == MODE_POP_BACK || mode_q == MODE_REMOVE);

	assign do_ins = acc && ins_ok;
	assign do_rem = fin_rem || (acc && popf_ok);
	assign ins_at = CW'(ins_at_x);
	assign rem_at = fin_rem ? CW'(tgt_q) : '0;

	always_comb begin
		used_next = used_q;
		if (do_ins) begin
			used_next = used_q + 1'b1;
		end else if (do_rem) begin
			used_next = used_q - 1'b1;
		end
	end

	// state machine: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (acc && go_scan) begin
					state_d = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				if (tok_exit.live) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// state machine: outputs
	always_comb begin
		case (state_q)
			FSM_SCAN: busy = 1'b1;
			default:  busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FSM_IDLE;
			launch_q <= 1'b0;
			used_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= acc && go_scan;
			used_q   <= used_next;
			strobe_q <= (acc && !go_scan) || done;
		end
	end

	// capture the command for a scan
	always_ff @(posedge clk) begin
		if (acc) begin
			mode_q <= mode;
			tgt_q  <= tgt_next;
			key_q  <= item_value;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (done) begin
			status_q <= ST_OK;
			count_q  <= POS_W'(used_next);
			if (mode_q == MODE_FIND) begin
				rd_q    <= '0;
				found_q <= tok_exit.hit ? tok_exit.where : FOUND_NONE;
			end else begin
				rd_q    <= tok_exit.value;
				found_q <= '0;
			end
		end else if (acc) begin
			status_q <= imm_status;
			count_q  <= POS_W'(used_next);
			rd_q     <= popf_ok ? elem[0] : '0;
			found_q  <= '0;
		end
	end

	assign strobe     = strobe_q;
	assign status     = status_q;
	assign read_value = rd_q;
	assign found_at   = found_q;
	assign count      = count_q;

	// token injected at the head of the chain
	always_comb begin
		tok[0]       = '0;
		tok[0].live  = launch_q;
	end

	// the cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_ctl_t         ctl;
		logic [DATA_W-1:0] lower_v, upper_v;
		logic              find_en, sel_pos;

		always_comb begin
			ctl.load_new   = do_ins && (ins_at == CW'(i));
			ctl.take_lower = do_ins && (CW'(i) > ins_at);
			ctl.take_upper = do_rem && (CW'(i) >= rem_at);
		end

		if (i == 0) begin : g_head
			assign lower_v = '0;
		end else begin : g_body
			assign lower_v = elem[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign upper_v = elem[i];
		end else begin : g_inner
			assign upper_v = elem[i+1];
		end

		assign find_en = (mode_q == MODE_FIND) && (CW'(i) < used_q);
		assign sel_pos = (mode_q != MODE_FIND) && (tgt_q == IW'(i));

		ial_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.new_value   (item_value),
			.lower_value (lower_v),
			.upper_value (upper_v),
			.key         (key_q),
			.find_en     (find_en),
			.sel_pos     (sel_pos),
			.where       (POS_W'(i)),
			.tok_in      (tok[i]),
			.tok_out     (tok[i+1]),
			.value       (elem[i])
		);

		assign live_vec[i] = tok[i+1].live;
	end

	// at most one probe token in flight
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(live_vec))
		else $error("more than one probe token in the chain");

	// a token only leaves the chain during a scan
	a_exit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok_exit.live |-> state_q == FSM_SCAN)
		else $error("probe token left the chain outside a scan");

	// no result is shown while a scan is running
	a_quiet_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_SCAN |-> !strobe)
		else $error("result strobe during a scan");

	// the end of a scan always delivers a result transfer
	a_scan_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe)
		else $error("scan ended without a result");

	// length never goes past the store
	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |=> used_q <= CW'(CAPACITY) && used_q != '0)
		else $error("length out of range after insert");

endmodule

// ===== tb/ial_checker.sv =====
// result checker for the indexed array list: predicts every command transfer
// on its own copy of the list and compares each result strobe with it
// depends on ial_pkg
module ial_checker #(
	parameter int CAPACITY = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  ial_pkg::mode_t                    mode,
	input  logic [ial_pkg::POS_W-1:0]         position,
	input  logic signed [ial_pkg::DATA_W-1:0] item_value,
	input  logic                              strobe,
	input  ial_pkg::status_t                  status,
	input  logic signed [ial_pkg::DATA_W-1:0] read_value,
	input  logic signed [ial_pkg::POS_W-1:0]  found_at,
	input  logic [ial_pkg::POS_W-1:0]         count,
	input  logic                              end_check,
	output int                                mismatches,
	output int                                pending,
	output int                                list_len,
	output int                                results_seen,
	output int                                full_hits,
	output int                                peak_len
);
	import ial_pkg::*;

	typedef struct {
		status_t           status;
		logic [DATA_W-1:0] read_value;
		logic [POS_W-1:0]  found_at;
		logic [POS_W-1:0]  count;
	} list_result_t;

	logic [DATA_W-1:0] shadow_cells [CAPACITY];
	int                shadow_len;
	list_result_t      awaited_results [$];
	list_result_t      want;

	// close the gap left by the element at index at and hand back its value
	function automatic logic [DATA_W-1:0] take_out(input int at);
		logic [DATA_W-1:0] v;
		v = shadow_cells[at];
		for (int i = at; i + 1 < shadow_len; i++)
			shadow_cells[i] = shadow_cells[i + 1];
		shadow_len--;
		return v;
	endfunction

	function automatic list_result_t apply_command(input mode_t m, input logic [POS_W-1:0] p,
			input logic [DATA_W-1:0] v);
		list_result_t r;
		int           at;
		r.status     = ST_OK;
		r.read_value = '0;
		r.found_at   = '0;
		case (m)
			MODE_PUSH_BACK, MODE_PUSH_FRONT, MODE_INSERT: begin
				if (m == MODE_PUSH_BACK)
					at = shadow_len;
				else if (m == MODE_PUSH_FRONT)
					at = 0;
				else
					at = int'(p);
				// index check wins over the full check
				if (at > shadow_len) begin
					r.status = ST_BAD_INDEX;
				end else if (shadow_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					for (int i = shadow_len; i > at; i--)
						shadow_cells[i] = shadow_cells[i - 1];
					shadow_cells[at] = v;
					shadow_len++;
				end
			end
			MODE_POP_BACK, MODE_POP_FRONT: begin
				if (shadow_len == 0)
					r.status = ST_EMPTY;
				else
					r.read_value = take_out((m == MODE_POP_BACK) ? shadow_len - 1 : 0);
			end
			MODE_REMOVE: begin
				if (int'(p) >= shadow_len)
					r.status = ST_BAD_INDEX;
				else
					r.read_value = take_out(int'(p));
			end
			MODE_FIND: begin
				r.found_at = FOUND_NONE;
				for (int i = 0; i < shadow_len; i++) begin
					if (shadow_cells[i] == v) begin
						r.found_at = POS_W'(i);
						break;
					end
				end
			end
			default: begin
				if (int'(p) >= shadow_len)
					r.status = ST_BAD_INDEX;
				else
					r.read_value = shadow_cells[int'(p)];
			end
		endcase
		r.count = POS_W'(shadow_len);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_len   = 0;
			mismatches   = 0;
			results_seen = 0;
			full_hits    = 0;
			peak_len     = 0;
			foreach (shadow_cells[i])
				shadow_cells[i] = '0;
			awaited_results.delete();
			pending  <= 0;
			list_len <= 0;
		end else begin
			// results first: a strobe never belongs to a transfer on the same edge
			if (strobe) begin
				results_seen++;
				if (awaited_results.size() == 0) begin
					$error("result with no command waiting: status %0d count %0d",
						status, count);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatches++;
					end
					if (read_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d",
							$signed(want.read_value), read_value);
						mismatches++;
					end
					if (found_at !== want.found_at) begin
						$error("found_at: expected %0d, got %0d",
							$signed(want.found_at), found_at);
						mismatches++;
					end
					if (count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, count);
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				want = apply_command(mode, position, item_value);
				awaited_results.push_back(want);
				if (want.status == ST_FULL)
					full_hits++;
				if (shadow_len > peak_len)
					peak_len = shadow_len;
			end
			if (end_check && awaited_results.size() != 0) begin
				$error("%0d results never arrived", awaited_results.size());
				mismatches += awaited_results.size();
				awaited_results.delete();
			end
			pending  <= awaited_results.size();
			list_len <= shadow_len;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// top of the indexed array list testbench: clock, reset, command stimulus
// and the verdict; results are predicted and checked in ial_checker
// depends on ial_pkg, ial_checker and indexed_array_list
module tb_top;
	import ial_pkg::*;

	localparam int CAPACITY    = 64;
	localparam int ITEMS_TOTAL = 1400;
	// last stretch of the run goes without sender gaps
	localparam int CALM_ITEMS  = 200;
	// slowest command holds busy while the token walks the whole chain, so allow a lot more
	localparam int QUIET_LIMIT = 8 * (CAPACITY + 8);
	localparam int SETTLE      = 2 * (CAPACITY + 2);

	typedef enum {
		BIAS_GROW,
		BIAS_SHRINK,
		BIAS_MIXED,
		BIAS_NOISE
	} bias_t;

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     start      = 1'b0;
	mode_t                    mode       = MODE_PUSH_BACK;
	logic [POS_W-1:0]         position   = '0;
	logic signed [DATA_W-1:0] item_value = '0;
	logic                     end_check  = 1'b0;
	logic                     busy;
	logic                     strobe;
	status_t                  status;
	logic signed [DATA_W-1:0] read_value;
	logic signed [POS_W-1:0]  found_at;
	logic [POS_W-1:0]         count;

	int mismatches;
	int pending;
	int list_len;
	int results_seen;
	int full_hits;
	int peak_len;
	int sent       = 0;
	int quiet_runs = 0;

	always #1 clk = ~clk;

	indexed_array_list #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.position  (position),
		.item_value(item_value),
		.strobe    (strobe),
		.status    (status),
		.read_value(read_value),
		.found_at  (found_at),
		.count     (count)
	);

	ial_checker #(
		.CAPACITY(CAPACITY)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.position    (position),
		.item_value  (item_value),
		.strobe      (strobe),
		.status      (status),
		.read_value  (read_value),
		.found_at    (found_at),
		.count       (count),
		.end_check   (end_check),
		.mismatches  (mismatches),
		.pending     (pending),
		.list_len    (list_len),
		.results_seen(results_seen),
		.full_hits   (full_hits),
		.peak_len    (peak_len)
	);

	// watchdog: cycles in which neither a command nor a result is transferred
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe) begin
				quiet_runs <= 0;
			end else if (quiet_runs >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end else begin
				quiet_runs <= quiet_runs + 1;
			end
		end
	end

	// hold one command until the transfer edge; busy read here is the
	// value the block saw at that edge
	task automatic send(input mode_t m, input logic [POS_W-1:0] p,
			input logic [DATA_W-1:0] v);
		start      <= 1'b1;
		mode       <= m;
		position   <= p;
		item_value <= v;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	// sender gap, with junk on the fields while start is low
	task automatic hold_off(input int cycles);
		start      <= 1'b0;
		mode       <= mode_t'($urandom_range(MODE_PUSH_BACK, MODE_GET));
		position   <= POS_W'($urandom);
		item_value <= $urandom;
		repeat (cycles) @(posedge clk);
	endtask

	// stop sending until every predicted result has been seen
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 9);
		case (r)
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			// a small pool so that finds hit and duplicates appear
			2, 3, 4: return DATA_W'($signed($urandom_range(0, 6)) - 3);
			default: return $urandom;
		endcase
	endfunction

	function automatic mode_t pick_mode(input bias_t bias);
		int unsigned r;
		r = $urandom_range(0, 99);
		case (bias)
			BIAS_GROW:   return (r < 75) ? mode_t'($urandom_range(MODE_PUSH_BACK, MODE_INSERT))
			                             : mode_t'($urandom_range(MODE_POP_BACK, MODE_GET));
			BIAS_SHRINK: return (r < 70) ? mode_t'($urandom_range(MODE_POP_BACK, MODE_REMOVE))
			                             : mode_t'($urandom_range(MODE_PUSH_BACK, MODE_GET));
			default:     return mode_t'($urandom_range(MODE_PUSH_BACK, MODE_GET));
		endcase
	endfunction

	// mostly positions near or inside the current length, some anywhere
	function automatic logic [POS_W-1:0] pick_pos(input bias_t bias, input int len);
		int unsigned r;
		int          lo;
		r  = $urandom_range(0, 99);
		lo = (len > 0) ? len - 1 : 0;
		if (bias == BIAS_NOISE || r < 10)
			return POS_W'($urandom_range(0, 127));
		else if (r < 30)
			return POS_W'($urandom_range(lo, len + 1));
		else
			return POS_W'($urandom_range(0, len));
	endfunction

	task automatic directed_part();
		// every command refused on an empty list, and a find that finds nothing
		send(MODE_GET,        7'd0,   32'd0);
		send(MODE_POP_BACK,   7'd0,   32'd0);
		send(MODE_POP_FRONT,  7'd0,   32'd0);
		send(MODE_REMOVE,     7'd0,   32'd0);
		send(MODE_FIND,       7'd0,   32'd5);
		send(MODE_INSERT,     7'd1,   32'd9);
		send(MODE_INSERT,     7'd127, 32'd9);
		// build a list from the value extremes, zero and minus one
		send(MODE_PUSH_BACK,  7'd127, 32'h7fff_ffff);
		send(MODE_PUSH_FRONT, 7'd127, 32'h8000_0000);
		send(MODE_INSERT,     7'd2,   32'd0);
		send(MODE_INSERT,     7'd1,   32'hffff_ffff);
		send(MODE_INSERT,     7'd0,   32'hffff_ffff);
		// duplicate value: find must report the first one
		send(MODE_FIND,       7'd0,   32'hffff_ffff);
		send(MODE_FIND,       7'd0,   32'd0);
		send(MODE_FIND,       7'd0,   32'd12345);
		send(MODE_GET,        7'd4,   32'd0);
		send(MODE_GET,        7'd5,   32'd0);
		send(MODE_GET,        7'd127, 32'd0);
		send(MODE_REMOVE,     7'd5,   32'd0);
		send(MODE_REMOVE,     7'd2,   32'd0);
		send(MODE_REMOVE,     7'd127, 32'd0);
		send(MODE_POP_BACK,   7'd0,   32'd0);
		send(MODE_POP_FRONT,  7'd0,   32'd0);
		send(MODE_PUSH_BACK,  7'd0,   32'd1);
	endtask

	task automatic random_part();
		bias_t bias;
		int    phase_len;
		bit    calm_phase;
		bit    first_phase;
		mode_t m;
		first_phase = 1'b1;
		while (sent < ITEMS_TOTAL) begin
			// the first phase fills the list so the full case shows up early
			if (first_phase) begin
				bias      = BIAS_GROW;
				phase_len = 220;
			end else begin
				bias      = bias_t'($urandom_range(0, 3));
				phase_len = $urandom_range(60, 150);
			end
			calm_phase = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < phase_len && sent < ITEMS_TOTAL; k++) begin
				m = pick_mode(bias);
				send(m, pick_pos(bias, list_len), pick_value());
				if (!calm_phase && sent < ITEMS_TOTAL - CALM_ITEMS &&
						$urandom_range(0, 3) == 0)
					hold_off($urandom_range(1, 6));
			end
			if (sent < ITEMS_TOTAL - CALM_ITEMS &&
					(first_phase || $urandom_range(0, 2) == 0))
				drain();
			first_phase = 1'b0;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_part();
		random_part();
		drain();
		// room for any stray strobe after the last one expected
		repeat (SETTLE) @(posedge clk);
		end_check <= 1'b1;
		@(posedge clk);
		end_check <= 1'b0;
		@(posedge clk);
		$display("%0d commands sent over all eight modes, %0d results checked",
			sent, results_seen);
		$display("list reached length %0d, %0d inserts refused as full",
			peak_len, full_hits);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
